FILE: sv/lmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmi_pkg: shared constants and types of the LU matrix inverse core
// Number format, storage geometry and the divider status bundle.
// ----------------------------------------------------------------------------
package lmi_pkg;

  localparam int MAX_N     = 8;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int SIZE_W    = 4;
  localparam int ACC_W     = 2 * DATA_W;
  localparam int PROD_W    = 2 * DATA_W;
  // magnitude bits of a dividend scaled by 2^FRAC_BITS
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int DEPTH     = MAX_N * MAX_N;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W     = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CNT_W     = $clog2(MAX_N + 2);
  localparam int LC_W      = ADDR_W + 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_N);

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ONE_DATA = DATA_W'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0]  HALF_ACC = ACC_W'(1 << (FRAC_BITS - 1));

  typedef struct packed {
    logic done;
    logic div_zero;
    logic sat;
  } div_res_t;

endpackage

FILE: sv/lu_matrix_inverse_core.sv
`timescale 1ns / 1ps
// Load: one element per cycle. After the last element the inverse is built in
// one RAM: each update reads its base and divisor, takes each product term
// through the single multiplier, saturates and writes back directly or via
// the bit-serial divider; each step to the next loop range takes its own check.
// Each inverse element then passes a RAM read, the output register and a hold.
// Reset clears control, flags and load count and sets the size to MAX_N.
// ----------------------------------------------------------------------------
// lu_matrix_inverse_core: fixed-point matrix inverse by Crout LU
// Loads an N x N matrix row-major, inverts it in place and streams the
// inverse row-major with last, singular and overflow marks.
// ----------------------------------------------------------------------------
module lu_matrix_inverse_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lmi_pkg::SIZE_W-1:0]          cfg_matrix_size_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lmi_pkg::DATA_W-1:0]   element_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lmi_pkg::DATA_W-1:0]   inverse_value_o,
  output logic                                last_element_o,
  output logic                                singular_o,
  output logic                                overflow_o
);
  import lmi_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_BASE  = 4'd2;
  localparam logic [3:0] S_TRD   = 4'd3;
  localparam logic [3:0] S_TMUL  = 4'd4;
  localparam logic [3:0] S_TACC  = 4'd5;
  localparam logic [3:0] S_POST  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_ORD   = 4'd8;
  localparam logic [3:0] S_OLD   = 4'd9;
  localparam logic [3:0] S_OHOLD = 4'd10;

  localparam logic [2:0] PH_ROW0 = 3'd0;
  localparam logic [2:0] PH_LCOL = 3'd1;
  localparam logic [2:0] PH_UROW = 3'd2;
  localparam logic [2:0] PH_LINV = 3'd3;
  localparam logic [2:0] PH_UINV = 3'd4;
  localparam logic [2:0] PH_MUL  = 3'd5;

  localparam logic [1:0] BK_ZERO = 2'd0;
  localparam logic [1:0] BK_ONE  = 2'd1;
  localparam logic [1:0] BK_MEM  = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-DATA_W){1'b0}}, DATA_MAX};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-DATA_W){1'b1}}, DATA_MIN};

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] r,
                                                input logic [CNT_W-1:0] c,
                                                input logic [CNT_W-1:0] n);
    return ADDR_W'(r[IDX_W-1:0]) * ADDR_W'(n) + ADDR_W'(c[IDX_W-1:0]);
  endfunction

  // control
  logic [3:0]        state_q, state_d;
  logic [2:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d, kend_q, kend_d, n_q, n_d;
  logic [LC_W-1:0]   lc_q, lc_d, total_q, total_d, oidx_q, oidx_d;
  logic [SIZE_W-1:0] size_q;
  logic              sing_q, sing_d, ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        bkind_q, bkind_d;
  logic              bneg_q, bneg_d, sub_q, sub_d, div_en_q, div_en_d;
  logic [ADDR_W-1:0] dst_q, dst_d;
  // datapath
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DATA_W-1:0] den_q, den_d;
  logic signed [DATA_W-1:0] out_val_q, out_val_d;
  logic                     out_last_q, out_last_d;

  logic [CNT_W-1:0]  n_cfg;
  logic [LC_W-1:0]   total_cfg;
  logic [LC_W-1:0]   lc_inc;

  // op decode
  logic              op_go, to_out;
  logic [2:0]        nx_phase;
  logic [CNT_W-1:0]  nx_i, nx_j;
  logic [1:0]        op_bkind;
  logic              op_bneg, op_sub, op_div;
  logic [CNT_W-1:0]  base_r, base_c, div_r, div_c, dst_r, dst_c, k_lo, k_hi;
  logic [CNT_W-1:0]  ta_r, ta_c, tb_r, tb_c;

  // RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_ra, ram_rb;
  logic [DATA_W-1:0] ram_wdata, rd_a, rd_b;

  logic signed [ACC_W-1:0]  base_ext, term_q16;
  logic signed [DATA_W-1:0] post_val;
  logic                     post_ovf;
  logic                     div_start;
  logic signed [DATA_W-1:0] div_quot;
  div_res_t                 div_res;

  lmi_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_ra),
    .raddr_b_i (ram_rb),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  lmi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (post_val),
    .den_i   (den_q),
    .quot_o  (div_quot),
    .res_o   (div_res)
  );

  always_comb begin
    if (size_q == '0) begin
      n_cfg = CNT_W'(1);
    end else if (size_q > SIZE_W'(MAX_N)) begin
      n_cfg = CNT_W'(MAX_N);
    end else begin
      n_cfg = CNT_W'(size_q);
    end
  end
  assign total_cfg = LC_W'(n_cfg) * LC_W'(n_cfg);
  assign lc_inc    = lc_q + LC_W'(1);

  // Walk the loop nest: pick the next update, step to the next range or go to output.
  always_comb begin
    op_go    = 1'b0;
    to_out   = 1'b0;
    nx_phase = phase_q;
    nx_i     = i_q;
    nx_j     = j_q;
    op_bkind = BK_ZERO;
    op_bneg  = 1'b0;
    op_sub   = 1'b1;
    op_div   = 1'b0;
    base_r   = j_q;
    base_c   = i_q;
    div_r    = j_q;
    div_c    = j_q;
    dst_r    = j_q;
    dst_c    = i_q;
    k_lo     = '0;
    k_hi     = '0;
    case (phase_q)
      PH_ROW0: begin
        if (i_q < n_q) begin
          op_go    = 1'b1;
          op_bkind = BK_MEM;
          base_r   = '0;
          dst_r    = '0;
          op_div   = 1'b1;
          div_r    = '0;
          div_c    = '0;
        end else begin
          nx_phase = PH_LCOL;
          nx_i     = CNT_W'(1);
          nx_j     = CNT_W'(1);
        end
      end
      PH_LCOL: begin
        if (i_q >= n_q) begin
          nx_phase = PH_LINV;
          nx_i     = '0;
          nx_j     = '0;
        end else if (j_q < n_q) begin
          op_go    = 1'b1;
          op_bkind = BK_MEM;
          k_hi     = i_q;
        end else begin
          nx_phase = PH_UROW;
          nx_j     = i_q + 1'b1;
        end
      end
      PH_UROW: begin
        if (j_q < n_q) begin
          op_go    = 1'b1;
          op_bkind = BK_MEM;
          base_r   = i_q;
          base_c   = j_q;
          dst_r    = i_q;
          dst_c    = j_q;
          k_hi     = i_q;
          op_div   = 1'b1;
          div_r    = i_q;
          div_c    = i_q;
        end else begin
          nx_phase = PH_LCOL;
          nx_i     = i_q + 1'b1;
          nx_j     = i_q + 1'b1;
        end
      end
      PH_LINV: begin
        if (i_q >= n_q) begin
          nx_phase = PH_UINV;
          nx_i     = '0;
          nx_j     = CNT_W'(1);
        end else if (j_q < n_q) begin
          op_go    = 1'b1;
          op_bkind = (i_q == j_q) ? BK_ONE : BK_ZERO;
          k_lo     = i_q;
          k_hi     = j_q;
          op_div   = 1'b1;
        end else begin
          nx_i     = i_q + 1'b1;
          nx_j     = i_q + 1'b1;
        end
      end
      PH_UINV: begin
        if (i_q >= n_q) begin
          nx_phase = PH_MUL;
          nx_i     = '0;
          nx_j     = '0;
        end else if (j_q < n_q) begin
          op_go    = 1'b1;
          op_bkind = BK_MEM;
          op_bneg  = 1'b1;
          base_r   = i_q;
          base_c   = j_q;
          dst_r    = i_q;
          dst_c    = j_q;
          k_lo     = i_q + 1'b1;
          k_hi     = j_q;
        end else begin
          nx_i     = i_q + 1'b1;
          nx_j     = i_q + CNT_W'(2);
        end
      end
      PH_MUL: begin
        if (i_q >= n_q) begin
          to_out   = 1'b1;
        end else if (j_q < n_q) begin
          op_go    = 1'b1;
          op_sub   = 1'b0;
          k_hi     = n_q;
          if (j_q >= i_q) begin
            op_bkind = BK_MEM;
            k_lo     = j_q + 1'b1;
          end else begin
            k_lo     = i_q;
          end
        end else begin
          nx_i     = i_q + 1'b1;
          nx_j     = '0;
        end
      end
      default: begin
        to_out = 1'b1;
      end
    endcase
  end

  // product-term operands
  always_comb begin
    ta_r = j_q;
    ta_c = k_q;
    tb_r = k_q;
    tb_c = i_q;
    case (phase_q)
      PH_UROW: begin
        ta_r = i_q;
        tb_c = j_q;
      end
      PH_UINV: begin
        ta_r = k_q;
        ta_c = j_q;
        tb_r = i_q;
        tb_c = k_q;
      end
      default: begin
        ta_r = j_q;
      end
    endcase
  end

  always_comb begin
    case (state_q)
      S_CHECK: begin
        ram_ra = addr_of(base_r, base_c, n_q);
        ram_rb = addr_of(div_r, div_c, n_q);
      end
      S_ORD: begin
        ram_ra = oidx_q[ADDR_W-1:0];
        ram_rb = oidx_q[ADDR_W-1:0];
      end
      default: begin
        ram_ra = addr_of(ta_r, ta_c, n_q);
        ram_rb = addr_of(tb_r, tb_c, n_q);
      end
    endcase
  end

  always_comb begin
    case (bkind_q)
      BK_MEM:  base_ext = {{(ACC_W-DATA_W){rd_a[DATA_W-1]}}, rd_a};
      BK_ONE:  base_ext = {{(ACC_W-DATA_W){1'b0}}, ONE_DATA};
      default: base_ext = '0;
    endcase
  end

  assign term_q16 = (prod_q + HALF_ACC) >>> FRAC_BITS;

  always_comb begin
    post_ovf = 1'b1;
    if (acc_q > ACC_MAX) begin
      post_val = DATA_MAX;
    end else if (acc_q < ACC_MIN) begin
      post_val = DATA_MIN;
    end else begin
      post_val = acc_q[DATA_W-1:0];
      post_ovf = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    kend_d      = kend_q;
    n_d         = n_q;
    lc_d        = lc_q;
    total_d     = total_q;
    oidx_d      = oidx_q;
    sing_d      = sing_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    bkind_d     = bkind_q;
    bneg_d      = bneg_q;
    sub_d       = sub_q;
    div_en_d    = div_en_q;
    dst_d       = dst_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    den_d       = den_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = dst_q;
    ram_wdata   = post_val;
    div_start   = 1'b0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ram_we    = lc_q < LC_W'(DEPTH);
          ram_waddr = lc_q[ADDR_W-1:0];
          ram_wdata = element_value_i;
          if (lc_inc >= total_cfg) begin
            lc_d    = '0;
            sing_d  = 1'b0;
            ovf_d   = 1'b0;
            n_d     = n_cfg;
            total_d = total_cfg;
            phase_d = PH_ROW0;
            i_d     = CNT_W'(1);
            j_d     = '0;
            state_d = S_CHECK;
          end else begin
            lc_d    = lc_inc;
          end
        end
      end
      S_CHECK: begin
        if (op_go) begin
          bkind_d  = op_bkind;
          bneg_d   = op_bneg;
          sub_d    = op_sub;
          div_en_d = op_div;
          dst_d    = addr_of(dst_r, dst_c, n_q);
          k_d      = k_lo;
          kend_d   = k_hi;
          state_d  = S_BASE;
        end else if (to_out) begin
          oidx_d   = '0;
          state_d  = S_ORD;
        end else begin
          phase_d  = nx_phase;
          i_d      = nx_i;
          j_d      = nx_j;
        end
      end
      S_BASE: begin
        acc_d   = bneg_q ? -base_ext : base_ext;
        den_d   = rd_b;
        state_d = (k_q < kend_q) ? S_TRD : S_POST;
      end
      S_TRD: begin
        state_d = S_TMUL;
      end
      S_TMUL: begin
        prod_d  = $signed(rd_a) * $signed(rd_b);
        state_d = S_TACC;
      end
      S_TACC: begin
        acc_d   = sub_q ? (acc_q - term_q16) : (acc_q + term_q16);
        k_d     = k_q + 1'b1;
        state_d = ((k_q + 1'b1) < kend_q) ? S_TRD : S_POST;
      end
      S_POST: begin
        ovf_d = ovf_q | post_ovf;
        if (div_en_q) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          ram_we  = 1'b1;
          state_d = S_CHECK;
          if (phase_q == PH_ROW0) begin
            i_d = i_q + 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          ram_we    = 1'b1;
          ram_wdata = div_quot;
          sing_d    = sing_q | div_res.div_zero;
          ovf_d     = ovf_q | div_res.sat;
          state_d   = S_CHECK;
          if (phase_q == PH_ROW0) begin
            i_d = i_q + 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      S_ORD: begin
        state_d = S_OLD;
      end
      S_OLD: begin
        out_val_d   = sing_q ? '0 : $signed(rd_a);
        out_last_d  = LC_W'(oidx_q + LC_W'(1)) == total_q;
        out_valid_d = 1'b1;
        state_d     = S_OHOLD;
      end
      S_OHOLD: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          oidx_d      = oidx_q + LC_W'(1);
          state_d     = out_last_q ? S_LOAD : S_ORD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      phase_q     <= PH_ROW0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      kend_q      <= '0;
      n_q         <= CNT_W'(MAX_N);
      lc_q        <= '0;
      total_q     <= '0;
      oidx_q      <= '0;
      sing_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      bkind_q     <= BK_ZERO;
      bneg_q      <= 1'b0;
      sub_q       <= 1'b0;
      div_en_q    <= 1'b0;
      size_q      <= SIZE_RESET;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      kend_q      <= kend_d;
      n_q         <= n_d;
      lc_q        <= lc_d;
      total_q     <= total_d;
      oidx_q      <= oidx_d;
      sing_q      <= sing_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      bkind_q     <= bkind_d;
      bneg_q      <= bneg_d;
      sub_q       <= sub_d;
      div_en_q    <= div_en_d;
      if (cfg_valid_i) begin
        size_q <= cfg_matrix_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q      <= dst_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    den_q      <= den_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign inverse_value_o = out_val_q;
  assign last_element_o  = out_last_q;
  assign singular_o      = sing_q;
  assign overflow_o      = ovf_q;

  a_out_only_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == S_OHOLD)
    else $error("result shown outside the output hold state");

  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_div_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_start)
    else $error("divider restarted back to back");

endmodule

FILE: sv/lmi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmi_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module lmi_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: sv/lmi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmi_div: fixed-point quotient unit
// Computes sat((num * 2^FRAC_BITS) / den), truncated toward zero, by
// restoring division one quotient bit per cycle; a zero den gives 0 and div_zero.
// ----------------------------------------------------------------------------
module lmi_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [lmi_pkg::DATA_W-1:0]   num_i,
  input  logic signed [lmi_pkg::DATA_W-1:0]   den_i,
  output logic signed [lmi_pkg::DATA_W-1:0]   quot_o,
  output lmi_pkg::div_res_t                   res_o
);
  import lmi_pkg::*;

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic              zero_q;
  logic [ITER_W-1:0] cnt_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] den_q;
  logic              neg_q;

  logic [DATA_W-1:0] num_mag;
  logic [DATA_W-1:0] den_mag;
  logic [DATA_W:0]   rem_shift;
  logic              rem_ge;
  logic [DATA_W:0]   rem_sub;
  logic              sat_pos;
  logic              sat_neg;

  assign num_mag   = num_i[DATA_W-1] ? (~num_i + 1'b1) : num_i;
  assign den_mag   = den_i[DATA_W-1] ? (~den_i + 1'b1) : den_i;
  assign rem_shift = {rem_q, quo_q[NUM_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, den_q};
  assign rem_sub   = rem_shift - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == '0) begin
          zero_q <= 1'b1;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          zero_q <= 1'b0;
          busy_q <= 1'b1;
          cnt_q  <= ITER_W'(NUM_W);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= NUM_W'(num_mag) << FRAC_BITS;
      rem_q <= '0;
      den_q <= den_mag;
      neg_q <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
    end else if (busy_q) begin
      rem_q <= rem_ge ? rem_sub[DATA_W-1:0] : rem_shift[DATA_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], rem_ge};
    end
  end

  assign sat_pos = !neg_q && (quo_q > NUM_W'(DATA_MAX));
  // negative limit magnitude is 2^(DATA_W-1), compared unsigned
  assign sat_neg = neg_q && (quo_q > {{(NUM_W-DATA_W){1'b0}}, DATA_MIN});

  always_comb begin
    if (zero_q) begin
      quot_o = '0;
    end else if (sat_pos) begin
      quot_o = DATA_MAX;
    end else if (sat_neg) begin
      quot_o = DATA_MIN;
    end else if (neg_q) begin
      quot_o = -$signed(quo_q[DATA_W-1:0]);
    end else begin
      quot_o = $signed(quo_q[DATA_W-1:0]);
    end
  end

  assign res_o.done     = done_q;
  assign res_o.div_zero = zero_q;
  assign res_o.sat      = !zero_q && (sat_pos || sat_neg);

endmodule

FILE: bench/lu_matrix_inverse_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_matrix_inverse_core_tb: self-checking bench of the LU matrix inverse core
// Loads matrices of assorted orders, predicts each inverse in fixed point with
// the same rounding and saturation, and checks every streamed element with its
// last, singular and overflow marks. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module lu_matrix_inverse_core_tb;
  import lmi_pkg::*;

  localparam int  DRAIN_CYCLES = 100;
  localparam int  CYCLE_LIMIT  = 3000000;
  localparam int  HOLD_CYCLES  = 800;
  localparam int  ITEM_TARGET  = 420;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     sing;
    logic                     ovf;
  } inv_elem_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [SIZE_W-1:0]           cfg_matrix_size_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic signed [DATA_W-1:0]    element_value_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [DATA_W-1:0]    inverse_value_o;
  logic                        last_element_o;
  logic                        singular_o;
  logic                        overflow_o;

  lu_matrix_inverse_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_matrix_size_i(cfg_matrix_size_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .element_value_i  (element_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .inverse_value_o  (inverse_value_o),
    .last_element_o   (last_element_o),
    .singular_o       (singular_o),
    .overflow_o       (overflow_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  logic signed [DATA_W-1:0] loaded_elems [DEPTH];
  int unsigned              elem_count;
  logic [SIZE_W-1:0]        size_reg;
  longint                   wk [MAX_N][MAX_N];
  bit                       sing_flag;
  bit                       ovf_flag;
  inv_elem_t                expected_inverse [$];

  function automatic longint sat32(longint x);
    if (x > longint'(DATA_MAX)) begin
      ovf_flag = 1'b1;
      return longint'(DATA_MAX);
    end
    if (x < longint'(DATA_MIN)) begin
      ovf_flag = 1'b1;
      return longint'(DATA_MIN);
    end
    return x;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint fx_div(longint a, longint b);
    if (b == 0) begin
      sing_flag = 1'b1;
      return 0;
    end
    return sat32((a * (longint'(1) << FRAC_BITS)) / b);
  endfunction

  function automatic void invert_matrix(int n);
    longint s;
    for (int i = 1; i < n; i++) wk[0][i] = fx_div(wk[0][i], wk[0][0]);
    for (int i = 1; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        s = 0;
        for (int k = 0; k < i; k++) s += fx_mul(wk[j][k], wk[k][i]);
        wk[j][i] = sat32(wk[j][i] - s);
      end
      if (i != n - 1) begin
        for (int j = i + 1; j < n; j++) begin
          s = 0;
          for (int k = 0; k < i; k++) s += fx_mul(wk[i][k], wk[k][j]);
          wk[i][j] = fx_div(sat32(wk[i][j] - s), wk[i][i]);
        end
      end
    end
    // inverse of the lower factor
    for (int i = 0; i < n; i++)
      for (int j = i; j < n; j++) begin
        s = longint'(1) << FRAC_BITS;
        if (i != j) begin
          s = 0;
          for (int k = i; k < j; k++) s -= fx_mul(wk[j][k], wk[k][i]);
          s = sat32(s);
        end
        wk[j][i] = fx_div(s, wk[j][j]);
      end
    // inverse of the upper factor, unit diagonal
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) begin
        s = 0;
        for (int k = i; k < j; k++)
          s += (k == i) ? wk[k][j] : fx_mul(wk[k][j], wk[i][k]);
        wk[i][j] = sat32(-s);
      end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        s = 0;
        for (int k = (i > j) ? i : j; k < n; k++)
          s += (j == k) ? wk[k][i] : fx_mul(wk[j][k], wk[k][i]);
        wk[j][i] = sat32(s);
      end
  endfunction

  function automatic void load_element(logic signed [DATA_W-1:0] v);
    int        n;
    inv_elem_t e;
    n = (size_reg == 0) ? 1 : ((size_reg > MAX_N) ? MAX_N : int'(size_reg));
    if (elem_count < DEPTH) loaded_elems[elem_count] = v;
    elem_count = (elem_count + 1) & 7'h7f;
    if (elem_count < n * n) return;
    elem_count = 0;
    sing_flag = 1'b0;
    ovf_flag = 1'b0;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) wk[r][c] = longint'(loaded_elems[r * n + c]);
    invert_matrix(n);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        e.value = sing_flag ? '0 : DATA_W'(wk[r][c]);
        e.last  = (r == n - 1) && (c == n - 1);
        e.sing  = sing_flag;
        e.ovf   = ovf_flag;
        expected_inverse = {expected_inverse, e};
      end
  endfunction

  // ------------------------------------------------------------------- driver
  logic signed [DATA_W-1:0] pending_elems [$];
  int  in_gap;
  bit  quiet;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) load_element(element_value_i);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (pending_elems.size() > 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            in_valid_i <= 1'b0;
            in_gap = $urandom_range(1, 9) - 1;
          end else begin
            in_valid_i <= 1'b1;
            element_value_i <= pending_elems.pop_front();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------- long output stall
  bit  hold_go;
  bit  hold_active;
  int  hold_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_active <= 1'b0;
      hold_left = HOLD_CYCLES;
    end else if (hold_go && hold_left > 0) begin
      hold_active <= 1'b1;
      hold_left--;
    end else begin
      hold_active <= 1'b0;
    end
  end

  // ------------------------------------------------------------------ monitor
  int out_gap;
  int mismatches;

  always @(posedge clk_i or negedge rst_ni) begin
    inv_elem_t got;
    inv_elem_t exp_e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {inverse_value_o, last_element_o, singular_o, overflow_o};
        if (expected_inverse.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected inverse element %h", got);
        end else begin
          exp_e = expected_inverse.pop_front();
          if (got !== exp_e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h last %b sing %b ovf %b, got %h last %b sing %b ovf %b",
                       exp_e.value, exp_e.last, exp_e.sing, exp_e.ovf,
                       got.value, got.last, got.sing, got.ovf);
          end
        end
      end
      if (hold_active) begin
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_ready_i <= 1'b0;
        out_gap--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        out_gap = $urandom_range(1, 9) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------ timeout
  int cycles;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ----------------------------------------------------------------- stimulus
  int items_sent;

  task automatic write_size(logic [SIZE_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_matrix_size_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_reg = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_elems.size() > 0 || in_valid_i || expected_inverse.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send(logic signed [DATA_W-1:0] v);
    pending_elems = {pending_elems, v};
    items_sent++;
  endtask

  function automatic logic signed [DATA_W-1:0] small_val(int mag);
    return DATA_W'($signed($urandom_range(0, 2 * mag)) - mag);
  endfunction

  // kind 0: diagonally dominant, 1: full-range noise, 2: zero leading pivot
  task automatic send_matrix(int n, int kind);
    logic signed [DATA_W-1:0] v;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        case (kind)
          0: begin
            if (r == c) begin
              v = DATA_W'($urandom_range(n * 2, n * 4) << FRAC_BITS) +
                  DATA_W'($urandom_range(0, 65535));
              if ($urandom_range(0, 1)) v = -v;
            end else begin
              v = small_val(2 << FRAC_BITS);
            end
          end
          1: v = $urandom;
          default: v = (r == 0 && c == 0) ? '0 : small_val(4 << FRAC_BITS);
        endcase
        send(v);
      end
  endtask

  int n_pick;
  int size_val;

  initial begin
    size_reg = SIZE_RESET;
    elem_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // order 1: zero pivot, unity, extremes, smallest negative
    write_size(4'd1);
    send('0);
    send(ONE_DATA);
    send(DATA_MAX);
    send(DATA_MIN);
    send(-1);
    wait_idle();
    // order 0 acts as order 1
    write_size(4'd0);
    send(-ONE_DATA);
    wait_idle();
    // order 2 with a zero leading pivot, then a zero second pivot
    write_size(4'd2);
    send('0); send(ONE_DATA); send(ONE_DATA); send(ONE_DATA);
    send(ONE_DATA); send(ONE_DATA); send(ONE_DATA); send(ONE_DATA);
    wait_idle();
    // shrink the order mid-load: the next element starts the computation
    write_size(4'd3);
    for (int i = 0; i < 5; i++) send(small_val(3 << FRAC_BITS));
    wait_idle();
    write_size(4'd2);
    send(small_val(3 << FRAC_BITS));
    wait_idle();

    // several small matrices back to back behind a long output stall
    hold_go = 1'b1;
    for (int m = 0; m < 6; m++) send_matrix(2, 0);
    wait_idle();

    write_size(4'd15);
    send_matrix(MAX_N, 0);
    wait_idle();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET * 3 / 4) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0:       size_val = MAX_N;
        1:       size_val = $urandom_range(MAX_N + 1, 15);
        2:       size_val = 0;
        default: size_val = $urandom_range(1, 4);
      endcase
      write_size(SIZE_W'(size_val));
      n_pick = (size_val == 0) ? 1 : ((size_val > MAX_N) ? MAX_N : size_val);
      for (int m = 0; m < $urandom_range(1, 3) && items_sent < ITEM_TARGET; m++) begin
        case ($urandom_range(0, 9))
          0:       send_matrix(n_pick, 1);
          1:       send_matrix(n_pick, 2);
          default: send_matrix(n_pick, 0);
        endcase
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: lu_matrix_inverse_core.f
sv/lmi_pkg.sv
sv/lmi_ram.sv
sv/lmi_div.sv
sv/lu_matrix_inverse_core.sv
bench/lu_matrix_inverse_core_tb.sv
